FILE: design/aes_pkg.sv
// aes-128 package: types, s-box, round constants and round functions
package aes_pkg;

  typedef logic [127:0] block_t;

  localparam int NumRounds = 10;

  // s-box lookup
  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    return tab[a];
  endfunction

  // round constant for round r (1..10)
  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1B;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // byte i of a block, byte 0 at the top
  function automatic logic [7:0] byte_of(input block_t b, input int i);
    return b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  // next round key from the previous one
  function automatic block_t next_key(input block_t p, input logic [3:0] r);
    logic [7:0] c [16];
    block_t o;
    c[0] = byte_of(p, 0) ^ sbox(byte_of(p, 13)) ^ rcon(r);
    c[1] = byte_of(p, 1) ^ sbox(byte_of(p, 14));
    c[2] = byte_of(p, 2) ^ sbox(byte_of(p, 15));
    c[3] = byte_of(p, 3) ^ sbox(byte_of(p, 12));
    for (int j = 4; j < 16; j++) c[j] = byte_of(p, j) ^ c[j-4];
    for (int j = 0; j < 16; j++) o[127-8*j -: 8] = c[j];
    return o;
  endfunction

  // one cipher round; mix selects mixcolumns
  function automatic block_t round_fn(input block_t s, input block_t k, input logic mix);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a, b, x, d, all;
    block_t o;
    for (int col = 0; col < 4; col++)
      for (int row = 0; row < 4; row++)
        t[row+4*col] = sbox(byte_of(s, row + 4*((col+row) & 3)));
    for (int col = 0; col < 4; col++) begin
      a = t[4*col]; b = t[4*col+1]; x = t[4*col+2]; d = t[4*col+3];
      all = a ^ b ^ x ^ d;
      m[4*col]   = mix ? (a ^ all ^ xtime(a ^ b)) : a;
      m[4*col+1] = mix ? (b ^ all ^ xtime(b ^ x)) : b;
      m[4*col+2] = mix ? (x ^ all ^ xtime(x ^ d)) : x;
      m[4*col+3] = mix ? (d ^ all ^ xtime(d ^ a)) : d;
    end
    for (int j = 0; j < 16; j++) o[127-8*j -: 8] = m[j] ^ byte_of(k, j);
    return o;
  endfunction

endpackage

FILE: design/aes_round_stage.sv
// one pipeline stage: a cipher round plus the matching key expansion step
module aes_round_stage #(
  parameter logic [3:0] ROUND = 4'd1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            vld_in,
  input  aes_pkg::block_t st_in,
  input  aes_pkg::block_t key_in,
  output logic            vld_out,
  output aes_pkg::block_t st_out,
  output aes_pkg::block_t key_out
);
  import aes_pkg::*;

  logic   vld_r;
  block_t st_r, key_r, key_nxt;

  assign key_nxt = next_key(key_in, ROUND);

  // stage registers move only when the pipe advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
    if (adv) begin
      key_r <= key_nxt;
      st_r  <= round_fn(st_in, key_nxt, ROUND != 4'(NumRounds));
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign key_out = key_r;
endmodule

FILE: design/aes128_block_encrypt_unit.sv
// aes-128 encryption top level: key registers, whitening stage and ten round stages
// eleven register stages: the whitening stage, which loads at the input transfer edge
// itself, then the ten round stages in order
// throughput: one block per cycle unless the output stalls, set by the fully unrolled
// round pipeline; the whole pipe holds on output stall; each block carries its own round keys
// synchronous active-low reset clears valid bits and sets the key to zero
module aes128_block_encrypt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low
);
  import aes_pkg::*;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  logic [63:0] key_high_r, key_low_r;
  logic        adv;
  logic        vld0_r;
  block_t      st0_r, rk0_r;
  logic        vld [NumRounds+1];
  block_t      st [NumRounds+1];
  block_t      rk [NumRounds+1];

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKeyHigh: key_high_r <= cfg_data;
        RegKeyLow:  key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe advances unless the output holds a block not yet taken
  assign adv      = !vld[NumRounds] || out_ready;
  assign in_ready = adv;

  // whitening stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
    end
    if (adv) begin
      rk0_r <= {key_high_r, key_low_r};
      st0_r <= {in_plain_high, in_plain_low} ^ {key_high_r, key_low_r};
    end
  end

  assign vld[0] = vld0_r;
  assign st[0]  = st0_r;
  assign rk[0]  = rk0_r;

  // round stages
  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes_round_stage #(.ROUND(4'(g))) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_in  (vld[g-1]),
      .st_in   (st[g-1]),
      .key_in  (rk[g-1]),
      .vld_out (vld[g]),
      .st_out  (st[g]),
      .key_out (rk[g])
    );
  end

  assign out_valid       = vld[NumRounds];
  assign out_cipher_high = st[NumRounds][127:64];
  assign out_cipher_low  = st[NumRounds][63:0];
endmodule

FILE: design/aes_checker.sv
// port-level checker for the aes-128 encryption unit
module aes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_cipher_high,
  input logic [63:0] out_cipher_low
);
  // stalled output holds its block
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_high) && $stable(out_cipher_low))
    else $error("output changed while stalled");

  // input is refused only while the output stalls
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // nothing comes out right after reset with no input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a block needs the full pipe depth before it can leave after reset
  a_latency: assert property (@(posedge clk)
    !rst_n |=> !out_valid [*10])
    else $error("block left the pipe too early");
endmodule

bind aes128_block_encrypt_unit aes_checker u_aes_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_cipher_high (out_cipher_high),
  .out_cipher_low  (out_cipher_low)
);

FILE: tb/sv/tb_aes128_block_encrypt_unit.sv
// testbench for the aes-128 block encryption unit: directed and random traffic vs a predictor
module tb_aes128_block_encrypt_unit;
  import aes_pkg::*;

  localparam logic [0:0] KeyHighIdx = 1'b0;
  localparam logic [0:0] KeyLowIdx = 1'b1;
  localparam int PipeLatency = 11;

  // expected ciphertext store with its own aes-128 model
  class cipher_scoreboard;
    block_t key;
    block_t cipher_q[$];
    int mismatches;
    int blocks_seen;

    static bit [7:0] sbox_tab [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

    function new();
      key = '0;
      mismatches = 0;
      blocks_seen = 0;
    endfunction

    static function bit [7:0] dbl(bit [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // full aes-128 encryption of one block
    function block_t encipher(block_t k, block_t pt);
      bit [7:0] rk [11][16];
      bit [7:0] st [16];
      bit [7:0] t [16];
      bit [7:0] rc;
      bit [7:0] a, b, x, d, sum;
      block_t res;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
        rk[0][i] = k[127-8*i -: 8];
        st[i] = pt[127-8*i -: 8] ^ rk[0][i];
      end
      // key schedule
      for (int r = 1; r < 11; r++) begin
        rk[r][0] = rk[r-1][0] ^ sbox_tab[rk[r-1][13]] ^ rc;
        rk[r][1] = rk[r-1][1] ^ sbox_tab[rk[r-1][14]];
        rk[r][2] = rk[r-1][2] ^ sbox_tab[rk[r-1][15]];
        rk[r][3] = rk[r-1][3] ^ sbox_tab[rk[r-1][12]];
        for (int j = 4; j < 16; j++) rk[r][j] = rk[r-1][j] ^ rk[r][j-4];
        rc = dbl(rc);
      end
      // rounds, last one without column mixing
      for (int r = 1; r < 11; r++) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++)
            t[w+4*c] = sbox_tab[st[w + 4*((c+w) % 4)]];
        for (int c = 0; c < 4; c++) begin
          a = t[4*c]; b = t[4*c+1]; x = t[4*c+2]; d = t[4*c+3];
          sum = a ^ b ^ x ^ d;
          if (r < 10) begin
            t[4*c] = a ^ sum ^ dbl(a ^ b);
            t[4*c+1] = b ^ sum ^ dbl(b ^ x);
            t[4*c+2] = x ^ sum ^ dbl(x ^ d);
            t[4*c+3] = d ^ sum ^ dbl(d ^ a);
          end
        end
        for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[r][i];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
      return res;
    endfunction

    function void note_plain(bit [63:0] hi, bit [63:0] lo);
      cipher_q.push_back(encipher(key, {hi, lo}));
      blocks_seen++;
    endfunction

    task report_mismatch(string what, bit [63:0] got, bit [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatches++;
    endtask

    task check_cipher(bit [63:0] hi, bit [63:0] lo);
      block_t want;
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected output", hi, 64'h0);
        return;
      end
      want = cipher_q.pop_front();
      if (hi !== want[127:64]) report_mismatch("cipher_high", hi, want[127:64]);
      if (lo !== want[63:0]) report_mismatch("cipher_low", lo, want[63:0]);
    endtask
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid, in_ready;
  logic [63:0] in_plain_high, in_plain_low;
  logic out_valid, out_ready;
  logic [63:0] out_cipher_high, out_cipher_low;

  int send_idle_pct, recv_idle_pct;
  int key_count;
  cipher_scoreboard sb;

  aes128_block_encrypt_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver backpressure
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_plain(in_plain_high, in_plain_low);
    if (rst_n && out_valid && out_ready) sb.check_cipher(out_cipher_high, out_cipher_low);
  end

  // present one block, with an optional random gap first; called just after an edge
  task send_block(input logic [63:0] hi, input logic [63:0] lo);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_plain_high <= hi;
    in_plain_low <= lo;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // let the pipe empty before touching the key
  task drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.cipher_q.size() != 0) @(posedge clk);
    repeat (PipeLatency + 2) @(posedge clk);
  endtask

  task write_key(input logic [63:0] hi, input logic [63:0] lo);
    cfg_we <= 1'b1;
    cfg_index <= KeyHighIdx;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= KeyLowIdx;
    cfg_data <= lo;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.key = {hi, lo};
    key_count++;
  endtask

  initial begin
    logic [63:0] kh, kl;
    sb = new();
    key_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = KeyHighIdx;
    cfg_data = '0;
    in_valid = 1'b0;
    in_plain_high = '0;
    in_plain_low = '0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero key straight out of reset, then the standard vector keys and the all-ones key
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
    drain();
    write_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
    send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
    drain();
    write_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
    drain();
    write_key(64'h2B7E151628AED2A6, 64'hABF7158809CF4F3C);
    send_block(64'h3243F6A8885A308D, 64'h313198A2E0370734);
    drain();

    // random phases under different flow-control mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 35 : 0;
      for (int ks = 0; ks < 4; ks++) begin
        kh = {$urandom, $urandom};
        kl = {$urandom, $urandom};
        if (ks == 0) begin
          kh = '0;
          kl = '0;
        end else if (ks == 1) begin
          kh = '1;
          kl = '1;
        end
        write_key(kh, kl);
        for (int n = 0; n < 100; n++)
          send_block({$urandom, $urandom}, {$urandom, $urandom});
        drain();
      end
    end

    $display("covered %0d blocks under %0d key settings with three backpressure mixes",
             sb.blocks_seen, key_count);
    if (sb.mismatches == 0 && sb.cipher_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("timeout with %0d blocks outstanding", sb.cipher_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
